// ===== rtl/core/qet_pkg.sv =====
// ----------------------------------------------------------------------------
// qet_pkg: shared types and constants of the quintic easing tween core
// Payload structs, control bundles, fixed-point constants and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qet_pkg;

  // Fixed-point layout.
  localparam int FRAC_W    = 16;            // fraction bits of Q16.16 and Q2.16
  localparam int POS_W     = 32;            // coordinate width
  localparam int DUR_W     = 32;            // duration width
  localparam int DT_W      = 24;            // time delta width
  localparam int ELAPSED_W = 33;            // elapsed time width
  localparam int Q_W       = FRAC_W + 2;    // normalized time, Q2.16
  localparam int M_W       = FRAC_W + 1;    // power base, at most 1.0
  localparam int PROD_W    = 2 * M_W - 1;   // power product, at most 2^32

  // Digit-serial multiplier layout.
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = 5;
  localparam int SHIFT_W    = DIGIT_W * MUL_DIGITS;
  localparam int DCNT_W     = $clog2(MUL_DIGITS);

  // Coordinate lane layout.
  localparam int DIFF_W = POS_W + 1;
  localparam int PP_W   = DIFF_W + DIGIT_W + 1;
  localparam int ACC_W  = 52;
  localparam int SUM_W  = ACC_W - FRAC_W;

  // Divider step counter: up to FRAC_W + 2 steps.
  localparam int DCYC_W = $clog2(FRAC_W + 3);

  localparam logic [Q_W-1:0]   ONE_Q16 = Q_W'(65536);
  localparam logic [Q_W-1:0]   TWO_Q16 = Q_W'(131072);
  localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
  localparam logic [DUR_W-1:0] DUR_RESET = 32'h0001_0000;

  // Ease mode codes.
  localparam logic [1:0] MODE_IN    = 2'd0;
  localparam logic [1:0] MODE_OUT   = 2'd1;
  localparam logic [1:0] MODE_INOUT = 2'd2;
  localparam logic [1:0] MODE_ZERO  = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z     = 3'd7;

  // Input item: one time tick.
  typedef struct packed {
    logic [DT_W-1:0] time_delta;
    logic            restart;
  } tick_t;

  // Result item: one position.
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    done_res;
  } pos_t;

  // Divider request.
  typedef struct packed {
    logic start;
    logic half;
  } div_ctl_t;

  // Coordinate lane sequencing.
  typedef struct packed {
    logic               load;
    logic               step;
    logic               fin;
    logic               half;
    logic [DIGIT_W-1:0] digit;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/quintic_ease_tween_core.sv =====
// ----------------------------------------------------------------------------
// quintic_ease_tween_core: quintic easing tween of a three-coordinate position
// Each tick advances a saturating elapsed time and yields the eased position
// between the configured start and end points, or the end point once done.
//
//   channel | signals                          | role
//   --------+----------------------------------+---------------------------
//   cfg     | cfg_we, cfg_index, cfg_data      | register write, no wait
//   tick    | tick_valid, tick_stall, tick     | input item, time tick
//   pos     | pos_valid, pos_stall, pos        | result item, position
//
// A tick while stopped yields nothing. End-point and zero results pass through
// the check and output states after the tick is taken. Eased results pass
// through the bit-serial divider, four digit-serial power passes, the blend
// factor and the lane digit steps before the output state.
// tick_stall is high from the accepted tick until its result is registered;
// a result waits in the output register while pos_stall is high.
// Reset is synchronous and sets the settings, the sequencer and pos_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_ease_tween_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  qet_pkg::tick_t                  tick,
  output logic                            pos_valid,
  input  logic                            pos_stall,
  output qet_pkg::pos_t                   pos
);

  import qet_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_POW   = 3'd3;
  localparam logic [2:0] S_ALPHA = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // Result sources.
  localparam logic [1:0] RES_END  = 2'd0;
  localparam logic [1:0] RES_ZERO = 2'd1;
  localparam logic [1:0] RES_LANE = 2'd2;

  // Blend factor forms from the final power.
  localparam logic [1:0] ALPHA_DIRECT = 2'd0;
  localparam logic [1:0] ALPHA_ONE    = 2'd1;
  localparam logic [1:0] ALPHA_TWO    = 2'd2;

  localparam int                POW_PASSES = 4;
  localparam logic [1:0]        PASS_LAST  = 2'(POW_PASSES - 1);
  localparam logic [DCNT_W-1:0] DIG_LAST   = DCNT_W'(MUL_DIGITS - 1);

  // Configuration registers.
  logic [1:0]       ease_mode;
  logic [DUR_W-1:0] duration;
  logic [POS_W-1:0] start_x, start_y, start_z;
  logic [POS_W-1:0] end_x, end_y, end_z;

  // Tween state and sequencing.
  logic [ELAPSED_W-1:0] elapsed;
  logic                 running;
  logic [2:0]           state;
  logic [1:0]           res_kind;
  logic                 res_done;
  logic [M_W-1:0]       m;
  logic [SHIFT_W-1:0]   mr;
  logic [PROD_W-1:0]    macc;
  logic [1:0]           amode;
  logic [1:0]           pcnt;
  logic [DCNT_W-1:0]    dcnt;
  logic [SHIFT_W-1:0]   ash;

  logic                   accept;
  logic                   out_free;
  logic                   run_now;
  logic [ELAPSED_W-1:0]   el_base;
  logic [ELAPSED_W:0]     el_sum;
  logic [ELAPSED_W-1:0]   el_sat;
  logic                   past_end;
  logic                   dur_zero;
  logic [M_W+DIGIT_W-1:0] pdig;
  logic [PROD_W-1:0]      macc_next;
  logic [M_W-1:0]         pw;
  logic [M_W-1:0]         m_sel;
  logic [1:0]             amode_sel;
  logic [Q_W-1:0]         alpha;
  logic [Q_W-1:0]         div_q;
  logic                   div_done;
  div_ctl_t               div_ctl;
  lane_ctl_t              lane_ctl;
  logic [POS_W-1:0]       lane_x, lane_y, lane_z;

  assign tick_stall = (state != S_IDLE);
  assign accept     = tick_valid && !tick_stall;
  assign out_free   = !pos_valid || !pos_stall;

  // Elapsed time update for an accepted tick.
  always_comb begin
    run_now = tick.restart || running;
    el_base = tick.restart ? '0 : elapsed;
    el_sum  = {1'b0, el_base} + (ELAPSED_W + 1)'(tick.time_delta);
    el_sat  = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
  end

  assign past_end = (elapsed > {1'b0, duration});
  assign dur_zero = (duration == '0);

  // One digit step of the power multiplier.
  assign pdig      = m * mr[SHIFT_W-1 -: DIGIT_W];
  assign macc_next = {macc[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(pdig);
  assign pw        = macc_next[PROD_W-1:FRAC_W];

  // Power base and blend form from the normalized time.
  always_comb begin
    unique case (ease_mode)
      MODE_IN: begin
        m_sel     = div_q[M_W-1:0];
        amode_sel = ALPHA_DIRECT;
      end
      MODE_OUT: begin
        m_sel     = M_W'(ONE_Q16 - div_q);
        amode_sel = ALPHA_ONE;
      end
      MODE_INOUT: begin
        if (div_q < ONE_Q16) begin
          m_sel     = div_q[M_W-1:0];
          amode_sel = ALPHA_DIRECT;
        end else begin
          m_sel     = M_W'(TWO_Q16 - div_q);
          amode_sel = ALPHA_TWO;
        end
      end
      MODE_ZERO: begin
        m_sel     = '0;
        amode_sel = ALPHA_DIRECT;
      end
    endcase
  end

  // Blend factor from the fifth power held in the multiplier register.
  always_comb begin
    unique case (amode)
      ALPHA_ONE: alpha = ONE_Q16 - {1'b0, mr[M_W-1:0]};
      ALPHA_TWO: alpha = TWO_Q16 - {1'b0, mr[M_W-1:0]};
      default:   alpha = {1'b0, mr[M_W-1:0]};
    endcase
  end

  // Divider and lane controls.
  always_comb begin
    div_ctl.start  = (state == S_CHK) && !past_end && !dur_zero && (ease_mode != MODE_ZERO);
    div_ctl.half   = (ease_mode == MODE_INOUT);
    lane_ctl.load  = (state == S_ALPHA);
    lane_ctl.step  = (state == S_STEP);
    lane_ctl.fin   = (state == S_FIN);
    lane_ctl.half  = (ease_mode == MODE_INOUT);
    lane_ctl.digit = ash[SHIFT_W-1 -: DIGIT_W];
  end

  qet_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (elapsed[DUR_W-1:0]),
    .den  (duration),
    .q    (div_q),
    .done (div_done)
  );

  qet_lane u_lane_x (
    .clk       (clk),
    .ctl       (lane_ctl),
    .start_val (start_x),
    .end_val   (end_x),
    .result    (lane_x)
  );

  qet_lane u_lane_y (
    .clk       (clk),
    .ctl       (lane_ctl),
    .start_val (start_y),
    .end_val   (end_y),
    .result    (lane_y)
  );

  qet_lane u_lane_z (
    .clk       (clk),
    .ctl       (lane_ctl),
    .start_val (start_z),
    .end_val   (end_z),
    .result    (lane_z)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ease_mode <= MODE_IN;
      duration  <= DUR_RESET;
      start_x   <= '0;
      start_y   <= '0;
      start_z   <= '0;
      end_x     <= '0;
      end_y     <= '0;
      end_z     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EASE_MODE: ease_mode <= cfg_data[1:0];
        REG_DURATION:  duration  <= cfg_data;
        REG_START_X:   start_x   <= cfg_data;
        REG_START_Y:   start_y   <= cfg_data;
        REG_START_Z:   start_z   <= cfg_data;
        REG_END_X:     end_x     <= cfg_data;
        REG_END_Y:     end_y     <= cfg_data;
        REG_END_Z:     end_z     <= cfg_data;
      endcase
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      elapsed  <= '0;
      running  <= 1'b0;
      res_kind <= RES_END;
      res_done <= 1'b0;
      pcnt     <= '0;
      dcnt     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && run_now) begin
            elapsed <= el_sat;
            running <= 1'b1;
            state   <= S_CHK;
          end
        end
        S_CHK: begin
          priority if (past_end) begin
            res_kind <= RES_END;
            res_done <= 1'b1;
            running  <= 1'b0;
            state    <= S_OUT;
          end else if (dur_zero) begin
            res_kind <= RES_END;
            res_done <= 1'b0;
            state    <= S_OUT;
          end else if (ease_mode == MODE_ZERO) begin
            res_kind <= RES_ZERO;
            res_done <= 1'b0;
            state    <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            m     <= m_sel;
            mr    <= {{(SHIFT_W-M_W){1'b0}}, m_sel};
            macc  <= '0;
            amode <= amode_sel;
            pcnt  <= '0;
            dcnt  <= '0;
            state <= S_POW;
          end
        end
        S_POW: begin
          if (dcnt == DIG_LAST) begin
            // End of one pass: the truncated product is the next multiplier.
            mr   <= {{(SHIFT_W-M_W){1'b0}}, pw};
            macc <= '0;
            dcnt <= '0;
            pcnt <= pcnt + 2'd1;
            if (pcnt == PASS_LAST) begin
              state <= S_ALPHA;
            end
          end else begin
            mr   <= {mr[SHIFT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            macc <= macc_next;
            dcnt <= dcnt + DCNT_W'(1);
          end
        end
        S_ALPHA: begin
          ash   <= {{(SHIFT_W-Q_W){1'b0}}, alpha};
          dcnt  <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          ash <= {ash[SHIFT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          if (dcnt == DIG_LAST) begin
            dcnt  <= '0;
            state <= S_FIN;
          end else begin
            dcnt <= dcnt + DCNT_W'(1);
          end
        end
        S_FIN: begin
          res_kind <= RES_LANE;
          res_done <= 1'b0;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      pos_valid <= 1'b1;
    end else if (pos_valid && !pos_stall) begin
      pos_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      pos.done_res <= res_done;
      unique case (res_kind)
        RES_ZERO: begin
          pos.pos_x <= '0;
          pos.pos_y <= '0;
          pos.pos_z <= '0;
        end
        RES_LANE: begin
          pos.pos_x <= lane_x;
          pos.pos_y <= lane_y;
          pos.pos_z <= lane_z;
        end
        default: begin
          pos.pos_x <= end_x;
          pos.pos_y <= end_y;
          pos.pos_z <= end_z;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A new result only comes from the output state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(pos_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_place: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  // A finished move leaves the block stopped.
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_done) |-> !running)
    else $error("done result while still running");

  // A tick while stopped yields nothing and leaves the block idle.
  a_stopped_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && !tick.restart && !running) |=> state == S_IDLE)
    else $error("stopped tick started work");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qet_div.sv =====
// ----------------------------------------------------------------------------
// qet_div: bit-serial normalized time divider
// Forms floor(num * 2^F / den) for num <= den, one quotient bit per cycle,
// with F = 16, or F = 17 when the half flag is set.
// ----------------------------------------------------------------------------
`default_nettype none

module qet_div (
  input  logic                   clk,
  input  logic                   rst,
  input  qet_pkg::div_ctl_t      ctl,
  input  logic [31:0]            num,
  input  logic [31:0]            den,
  output logic [qet_pkg::Q_W-1:0] q,
  output logic                   done
);

  import qet_pkg::*;

  logic              busy;
  logic              first;
  logic [DCYC_W-1:0] cnt;
  logic [DUR_W:0]    r;
  logic [DUR_W:0]    rs;
  logic [DUR_W:0]    rdiff;
  logic              ge;

  // The first step takes the integer bit without a shift.
  always_comb begin
    rs    = first ? r : {r[DUR_W-1:0], 1'b0};
    ge    = (rs >= {1'b0, den});
    rdiff = rs - {1'b0, den};
  end

  // Restoring division, one step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      first <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= ctl.half ? DCYC_W'(FRAC_W + 2) : DCYC_W'(FRAC_W + 1);
        r     <= {1'b0, num};
        q     <= '0;
      end else if (busy) begin
        r     <= ge ? rdiff : rs;
        q     <= {q[Q_W-2:0], ge};
        first <= 1'b0;
        cnt   <= cnt - DCYC_W'(1);
        if (cnt == DCYC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qet_lane.sv =====
// ----------------------------------------------------------------------------
// qet_lane: digit-serial coordinate interpolation lane
// Multiplies (end - start) by the blend factor one digit per cycle, then
// shifts, adds the start point and saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module qet_lane (
  input  logic                       clk,
  input  qet_pkg::lane_ctl_t         ctl,
  input  logic [qet_pkg::POS_W-1:0]  start_val,
  input  logic [qet_pkg::POS_W-1:0]  end_val,
  output logic [qet_pkg::POS_W-1:0]  result
);

  import qet_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PP_W-1:0]   pp;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         acc_next;
  logic [SUM_W-1:0]         shv;
  logic [SUM_W-1:0]         sum;
  logic [POS_W-1:0]         sat;

  // One digit of the blend factor against the signed difference.
  assign pp       = diff * $signed({1'b0, ctl.digit});
  assign acc_next = {acc[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                  + {{(ACC_W-PP_W){pp[PP_W-1]}}, pp};

  // Floor shift by 16, or by 17 for the in-out curve, then add and saturate.
  always_comb begin
    shv = ctl.half ? {acc[ACC_W-1], acc[ACC_W-1:FRAC_W+1]} : acc[ACC_W-1:FRAC_W];
    sum = {{(SUM_W-POS_W){start_val[POS_W-1]}}, start_val} + shv;
    if (sum[SUM_W-1:POS_W-1] == {(SUM_W-POS_W+1){sum[SUM_W-1]}}) begin
      sat = sum[POS_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = POS_MIN;
    end else begin
      sat = POS_MAX;
    end
  end

  // Lane registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      diff <= $signed({end_val[POS_W-1], end_val}) - $signed({start_val[POS_W-1], start_val});
      acc  <= '0;
    end else if (ctl.step) begin
      acc <= acc_next;
    end
    if (ctl.fin) begin
      result <= sat;
    end
  end

endmodule

`default_nettype wire

// ===== test/quintic_ease_tween_checker.sv =====
// ----------------------------------------------------------------------------
// quintic_ease_tween_checker: position predictor and scoreboard
// Watches the register port and both item channels of the tween core, keeps
// its own copy of the move settings and elapsed time, works out the position
// for every accepted tick and compares it field by field with what comes out.
// ----------------------------------------------------------------------------

module quintic_ease_tween_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [qet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          tick_valid,
  input  logic                          tick_stall,
  input  qet_pkg::tick_t                tick,
  input  logic                          pos_valid,
  input  logic                          pos_stall,
  input  qet_pkg::pos_t                 pos,
  output int                            fail_count,
  output int                            pending,
  output logic                          moving,
  output int                            ticks_seen,
  output int                            positions_seen,
  output int                            arrivals_seen
);

  // Mirror of the move settings.
  logic [1:0]         mode_q;
  logic [31:0]        dur_q;
  logic signed [31:0] from_q [3];
  logic signed [31:0] to_q [3];

  // Mirror of the tween state.
  logic [32:0] elapsed_q;
  logic        running_q;

  // Positions still owed by the core, oldest first.
  qet_pkg::pos_t owed_q [$];

  // Fifth power of a Q2.16 magnitude, truncating after every product.
  function automatic logic [63:0] fifth_power(input logic [63:0] m);
    logic [63:0] p;
    p = m;
    repeat (4) p = (p * m) >> qet_pkg::FRAC_W;
    return p;
  endfunction

  // One coordinate between its start and end at weight alpha, saturated.
  function automatic logic signed [31:0] blend(input logic signed [31:0] s,
                                               input logic signed [31:0] e,
                                               input logic [63:0] alpha,
                                               input int sh);
    longint d;
    longint v;
    d = longint'(e) - longint'(s);
    v = longint'(s) + ((d * longint'(alpha)) >>> sh);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Advance the tween by one tick; returns 1 when the tick yields a position.
  function automatic logic advance(input qet_pkg::tick_t t, output qet_pkg::pos_t p);
    logic [63:0] sum;
    logic [63:0] q;
    logic [63:0] alpha;
    int          sh;
    p = '0;
    sh = qet_pkg::FRAC_W;
    if (t.restart) begin
      elapsed_q = '0;
      running_q = 1'b1;
    end
    if (!running_q) return 1'b0;

    // Elapsed time saturates instead of wrapping.
    sum = {31'b0, elapsed_q} + {40'b0, t.time_delta};
    if (sum > 64'h1_FFFF_FFFF) sum = 64'h1_FFFF_FFFF;
    elapsed_q = sum[32:0];

    // Past the end: report the end point once and stop.
    if (elapsed_q > {1'b0, dur_q}) begin
      p = {to_q[0], to_q[1], to_q[2], 1'b1};
      running_q = 1'b0;
      return 1'b1;
    end
    if (dur_q == '0) begin
      p = {to_q[0], to_q[1], to_q[2], 1'b0};
      return 1'b1;
    end

    case (mode_q)
      qet_pkg::MODE_IN: begin
        q = ({31'b0, elapsed_q} << 16) / {32'b0, dur_q};
        alpha = fifth_power(q);
      end
      qet_pkg::MODE_OUT: begin
        q = ({31'b0, elapsed_q} << 16) / {32'b0, dur_q};
        alpha = 64'(qet_pkg::ONE_Q16) - fifth_power(64'(qet_pkg::ONE_Q16) - q);
      end
      qet_pkg::MODE_INOUT: begin
        // Time is measured against half the duration, weight spans 0 to 2.
        q = ({31'b0, elapsed_q} << 17) / {32'b0, dur_q};
        if (q < 64'(qet_pkg::ONE_Q16)) begin
          alpha = fifth_power(q);
        end else begin
          alpha = 64'(qet_pkg::TWO_Q16) - fifth_power(64'(qet_pkg::TWO_Q16) - q);
        end
        sh = qet_pkg::FRAC_W + 1;
      end
      default: begin
        return 1'b1;
      end
    endcase
    p.pos_x = blend(from_q[0], to_q[0], alpha, sh);
    p.pos_y = blend(from_q[1], to_q[1], alpha, sh);
    p.pos_z = blend(from_q[2], to_q[2], alpha, sh);
    return 1'b1;
  endfunction

  // Register writes, result comparison and prediction, one edge at a time.
  always @(posedge clk) begin : watch
    qet_pkg::pos_t want;
    qet_pkg::pos_t oldest;
    if (rst) begin
      mode_q = qet_pkg::MODE_IN;
      dur_q = qet_pkg::DUR_RESET;
      for (int i = 0; i < 3; i++) begin
        from_q[i] = '0;
        to_q[i] = '0;
      end
      elapsed_q = '0;
      running_q = 1'b0;
      owed_q.delete();
      pending = 0;
      fail_count = 0;
      ticks_seen = 0;
      positions_seen = 0;
      arrivals_seen = 0;
      moving <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          qet_pkg::REG_EASE_MODE: mode_q = cfg_data[1:0];
          qet_pkg::REG_DURATION:  dur_q = cfg_data;
          qet_pkg::REG_START_X:   from_q[0] = cfg_data;
          qet_pkg::REG_START_Y:   from_q[1] = cfg_data;
          qet_pkg::REG_START_Z:   from_q[2] = cfg_data;
          qet_pkg::REG_END_X:     to_q[0] = cfg_data;
          qet_pkg::REG_END_Y:     to_q[1] = cfg_data;
          qet_pkg::REG_END_Z:     to_q[2] = cfg_data;
          default: ;
        endcase
      end

      // A position leaving the core must match the oldest one owed.
      if (pos_valid && !pos_stall) begin
        positions_seen++;
        if (pos.done_res) arrivals_seen++;
        if (owed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected position x=%h y=%h z=%h done=%b with none owed",
                     pos.pos_x, pos.pos_y, pos.pos_z, pos.done_res);
        end else begin
          oldest = owed_q.pop_front();
          if (pos !== oldest) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h %h %h done=%b, got %h %h %h done=%b",
                       oldest.pos_x, oldest.pos_y, oldest.pos_z, oldest.done_res,
                       pos.pos_x, pos.pos_y, pos.pos_z, pos.done_res);
          end
        end
      end

      if (tick_valid && !tick_stall) begin
        ticks_seen++;
        if (advance(tick, want)) owed_q.push_back(want);
      end
      pending = owed_q.size();
      moving <= running_q;
    end
  end

endmodule

// ===== test/quintic_ease_tween_core_tb.sv =====
// ----------------------------------------------------------------------------
// quintic_ease_tween_core_tb: testbench of the quintic easing tween core
// Drives directed moves over the extremes of every setting and then random
// moves with random tick sizes and random gaps and stalls on both channels;
// a separate checker predicts every position and keeps the failure count.
// ----------------------------------------------------------------------------

module quintic_ease_tween_core_tb;

  localparam int ITEMS  = 1700;   // random ticks that reach a running move
  localparam int SETTLE = 64;     // cycles that cover a tick still in flight
  localparam int LIMIT  = 2000;   // cycles without any transfer before giving up

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [qet_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;
  logic                          tick_valid = 1'b0;
  logic                          tick_stall;
  qet_pkg::tick_t                tick = '0;
  logic                          pos_valid;
  logic                          pos_stall = 1'b0;
  qet_pkg::pos_t                 pos;

  int   fail_count;
  int   pending;
  logic moving;
  int   ticks_seen;
  int   positions_seen;
  int   arrivals_seen;

  logic quiet = 1'b0;   // no gaps and no stalls while set
  int   settings = 0;
  int   hold = 0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  quintic_ease_tween_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .pos_valid  (pos_valid),
    .pos_stall  (pos_stall),
    .pos        (pos)
  );

  quintic_ease_tween_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .tick_valid     (tick_valid),
    .tick_stall     (tick_stall),
    .tick           (tick),
    .pos_valid      (pos_valid),
    .pos_stall      (pos_stall),
    .pos            (pos),
    .fail_count     (fail_count),
    .pending        (pending),
    .moving         (moving),
    .ticks_seen     (ticks_seen),
    .positions_seen (positions_seen),
    .arrivals_seen  (arrivals_seen)
  );

  // Position receiver: stalls each item for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold = 0;
      pos_stall <= 1'b0;
    end else if (pos_valid && !pos_stall) begin
      hold = quiet ? 0 : $urandom_range(0, 5);
      pos_stall <= (hold != 0);
    end else if (pos_valid && hold != 0) begin
      hold = hold - 1;
      pos_stall <= (hold != 0);
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || cfg_we || (tick_valid && !tick_stall) || (pos_valid && !pos_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one tick after a drawn gap and return at the edge that takes it.
  task automatic send_tick(input logic [23:0] dt, input logic rs);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= {dt, rs};
    do @(posedge clk); while (tick_stall);
  endtask

  // Hold off until every owed position is out and the core has gone quiet.
  task automatic drain();
    tick_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qet_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Load a whole move; upper bits of the mode word are random filler.
  task automatic set_move(input logic [1:0] mode, input logic [31:0] dur,
                          input logic [31:0] sx, input logic [31:0] sy,
                          input logic [31:0] sz, input logic [31:0] ex,
                          input logic [31:0] ey, input logic [31:0] ez);
    drain();
    write_reg(qet_pkg::REG_EASE_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)), mode});
    write_reg(qet_pkg::REG_DURATION, dur);
    write_reg(qet_pkg::REG_START_X, sx);
    write_reg(qet_pkg::REG_START_Y, sy);
    write_reg(qet_pkg::REG_START_Z, sz);
    write_reg(qet_pkg::REG_END_X, ex);
    write_reg(qet_pkg::REG_END_Y, ey);
    write_reg(qet_pkg::REG_END_Z, ez);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] dur;
    logic [31:0] span;
    logic [31:0] r;
    logic [23:0] dt;
    logic        rs;
    int          busy;
    int          n;
    busy = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a tick while stopped, then a restart at time zero.
    send_tick(24'd100, 1'b0);
    send_tick(24'd0, 1'b1);

    // Ease in between opposite extremes; the last tick lands after the end.
    set_move(qet_pkg::MODE_IN, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
             32'h8000_0000, 32'h7FFF_FFFF, 32'd12345);
    send_tick(24'd0, 1'b1);
    send_tick(24'd16384, 1'b0);
    send_tick(24'hFF_FFFF, 1'b0);
    send_tick(24'd5, 1'b0);

    // Ease out reaching exactly the duration, then one step past it.
    set_move(qet_pkg::MODE_OUT, 32'h0001_0000, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
    send_tick(24'h00_8000, 1'b1);
    send_tick(24'h00_8000, 1'b0);
    send_tick(24'd1, 1'b0);

    // Ease in-out through the midpoint, with a restart in the middle.
    set_move(qet_pkg::MODE_INOUT, 32'h0002_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_0000);
    send_tick(24'h01_0000, 1'b1);
    send_tick(24'h00_8000, 1'b1);
    send_tick(24'h01_8000, 1'b0);
    send_tick(24'hFF_FFFF, 1'b0);

    // Zero-position mode over the longest duration.
    set_move(qet_pkg::MODE_ZERO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_tick(24'hFF_FFFF, 1'b1);
    send_tick(24'd0, 1'b0);

    // Zero duration: end point while time stands still, done once it moves.
    set_move(qet_pkg::MODE_IN, 32'h0, 32'd7, 32'd8, 32'd9,
             32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    send_tick(24'd0, 1'b1);
    send_tick(24'd0, 1'b0);
    send_tick(24'd1, 1'b0);

    // Shortest nonzero duration in in-out mode: full weight at the end.
    set_move(qet_pkg::MODE_INOUT, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
             32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_tick(24'd1, 1'b1);

    // Random moves: mostly restarts followed by ticks sized to the duration.
    while (busy < ITEMS) begin
      case ($urandom_range(0, 9))
        0: dur = 32'h0;
        1: dur = $urandom_range(1, 64);
        2: dur = $urandom;
        3: dur = 32'hFFFF_FFFF;
        default: dur = $urandom_range(1024, 32'h0400_0000);
      endcase
      set_move(2'($urandom_range(0, 3)), dur, pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord());
      quiet <= ($urandom_range(0, 3) == 0);
      span = dur / $urandom_range(3, 30);
      if (span == 0) span = 1;
      if (span > 32'h00FF_FFFF) span = 32'h00FF_FFFF;
      n = $urandom_range(10, 60);
      for (int i = 0; i < n; i++) begin
        rs = (i == 0) || (!moving && $urandom_range(0, 3) != 0) ||
             ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 15))
          0: dt = '0;
          1: dt = 24'($urandom);
          2: dt = 24'hFF_FFFF;
          default: begin
            r = $urandom_range(0, 2 * span);
            dt = (r > 32'h00FF_FFFF) ? 24'hFF_FFFF : r[23:0];
          end
        endcase
        if (rs || moving) busy++;
        send_tick(dt, rs);
      end
    end

    quiet <= 1'b0;
    drain();
    $display("Sent %0d ticks over %0d move settings; %0d positions checked, %0d ends.",
             ticks_seen, settings, positions_seen, arrivals_seen);
    $display("All four ease modes, zero and full-range durations and extreme coordinates were used.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/qet_pkg.sv
rtl/core/qet_div.sv
rtl/core/qet_lane.sv
rtl/core/quintic_ease_tween_core.sv
test/quintic_ease_tween_checker.sv
test/quintic_ease_tween_core_tb.sv
